FILE: sv/atcp_pkg.sv
// atcp_pkg: shared types and constants for the atan2 cubic angle block.
// No dependencies.
package atcp_pkg;

  localparam int ANG_W      = 9;
  localparam int QDEG_W     = 8;
  localparam int VDEG_W     = 15;
  localparam int RECIP_W    = 10;
  localparam int QUEUE_DEPTH = 4;

  // cubic coefficients, centidegrees
  localparam int unsigned C_LIN  = 448;
  localparam int unsigned C_OFS  = 954;
  localparam int unsigned C_MID  = 5894;
  localparam int unsigned INNER_EXTRA = 11;
  localparam int unsigned MID_EXTRA   = 13;
  localparam int unsigned MAG_EXTRA   = 15;

  // unfold bases, centidegrees
  localparam int unsigned CDEG_HALF = 18000;
  localparam int unsigned CDEG_QTR  = 9000;

  // divide by 100: (v * 655) >> 16 plus one correction
  localparam int unsigned RECIP100    = 655;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned CENTI       = 100;

  localparam logic signed [ANG_W-1:0] ANG_ZERO = 9'sd0;
  localparam logic signed [ANG_W-1:0] ANG_P90  = 9'sd90;
  localparam logic signed [ANG_W-1:0] ANG_M90  = -9'sd90;
  localparam logic signed [ANG_W-1:0] ANG_P180 = 9'sd180;

  typedef struct packed {
    logic                    spec;
    logic signed [ANG_W-1:0] spec_deg;
    logic                    low;
    logic                    xneg;
    logic                    yneg;
  } atcp_cls_t;

endpackage

FILE: sv/atcp_fifo.sv
// atcp_fifo: small register queue between front and back.
// No dependencies.
module atcp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: sv/atcp_front.sv
// atcp_front: input word intake, octant fold, axis cases and ratio divider pipeline.
// Depends on atcp_pkg.
module atcp_front
  import atcp_pkg::*;
#(
  parameter int COORD_WIDTH     = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [RATIO_FRAC_BITS:0]      q_z,
  output atcp_cls_t                     q_cls
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = RATIO_FRAC_BITS;
  localparam int Z_W = F + 1;
  localparam int NST = F + 2;

  logic             vld_r  [0:NST-1];
  logic [W:0]       rem_r  [0:NST-1];
  logic [W-1:0]     den_r  [0:NST-1];
  logic [Z_W-1:0]   quo_r  [0:NST-1];
  atcp_cls_t        cls_r  [0:NST-1];

  logic             en;
  logic [W-1:0]     x_u, y_u, ax, ay;
  logic             xz, yz;
  atcp_cls_t        cls_nxt;

  assign en       = !vld_r[NST-1] || !q_full;
  assign in_stall = !en;
  assign q_push   = vld_r[NST-1] && !q_full;
  assign q_z      = quo_r[NST-1];
  assign q_cls    = cls_r[NST-1];

  always_comb begin
    x_u = $unsigned(in_coord_x);
    y_u = $unsigned(in_coord_y);
    ax  = x_u[W-1] ? W'(~x_u + 1'b1) : x_u;
    ay  = y_u[W-1] ? W'(~y_u + 1'b1) : y_u;
    xz  = (x_u == '0);
    yz  = (y_u == '0);
    cls_nxt.spec = xz || yz;
    cls_nxt.low  = (ay < ax);
    cls_nxt.xneg = x_u[W-1];
    cls_nxt.yneg = y_u[W-1];
    if (xz && yz) begin
      cls_nxt.spec_deg = ANG_ZERO;
    end else if (xz) begin
      cls_nxt.spec_deg = y_u[W-1] ? ANG_M90 : ANG_P90;
    end else begin
      cls_nxt.spec_deg = x_u[W-1] ? ANG_P180 : ANG_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, (cls_nxt.low ? ay : ax)};
      den_r[0] <= cls_nxt.low ? ax : ay;
      quo_r[0] <= '0;
      cls_r[0] <= cls_nxt;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar i = 0; i < NST - 1; i++) begin : g_div
    logic [W:0]   r_in;
    logic         ge;
    logic [W:0]   r_out;

    always_comb begin
      r_in  = (i == 0) ? rem_r[i] : {rem_r[i][W-1:0], 1'b0};
      ge    = (r_in >= {1'b0, den_r[i]});
      r_out = ge ? (r_in - {1'b0, den_r[i]}) : r_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= r_out;
        den_r[i+1] <= den_r[i];
        quo_r[i+1] <= {quo_r[i][Z_W-2:0], ge};
        cls_r[i+1] <= cls_r[i];
      end
    end
  end

endmodule

FILE: sv/atcp_back.sv
// atcp_back: cubic evaluation, octant unfold and degree truncation pipeline.
// Depends on atcp_pkg.
module atcp_back
  import atcp_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  logic [RATIO_FRAC_BITS:0] q_z,
  input  atcp_cls_t               q_cls,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ANG_W-1:0] out_angle_deg
);

  localparam int F       = RATIO_FRAC_BITS;
  localparam int Z_W     = F + 1;
  localparam int INNER_W = F + INNER_EXTRA;
  localparam int MID_W   = F + MID_EXTRA;
  localparam int MAG_W   = F + MAG_EXTRA;
  localparam int P1_W    = Z_W + INNER_W;
  localparam int P2_W    = Z_W + MID_W;
  localparam int P3_W    = VDEG_W + RECIP_W;

  logic                 en;
  logic [7:1]           v_r;
  atcp_cls_t            c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r;
  logic [Z_W-1:0]       z1_r, z2_r, z3_r;
  logic [INNER_W-1:0]   inner1_r, m1_2_r;
  logic [MID_W-1:0]     mid3_r, a4_r;
  logic [VDEG_W-1:0]    vd5_r, vd6_r, vd7_r;
  logic [P3_W-1:0]      p6_r;
  logic [QDEG_W-1:0]    q0_7_r;
  logic [VDEG_W-1:0]    prod7_r;
  logic                 out_vld_r;
  logic signed [ANG_W-1:0] ang_r;

  logic [INNER_W-1:0]   inner_nxt;
  logic [P1_W-1:0]      prod1;
  logic [MID_W-1:0]     mid_nxt;
  logic [P2_W-1:0]      prod2;
  logic [MAG_W-1:0]     mag;
  logic [P3_W-1:0]      p_nxt;
  logic [VDEG_W-1:0]    rem;
  logic [QDEG_W-1:0]    qd;
  logic [ANG_W-1:0]     qx;
  logic signed [ANG_W-1:0] ang_nxt;

  assign en            = !out_vld_r || !out_stall;
  assign q_pop         = en && !q_empty;
  assign out_valid     = out_vld_r;
  assign out_angle_deg = ang_r;

  always_comb begin
    inner_nxt = INNER_W'(q_z) * INNER_W'(C_LIN) + (INNER_W'(C_OFS) << F);
    prod1     = P1_W'(z1_r) * P1_W'(inner1_r);
    mid_nxt   = (MID_W'(C_MID) << F) - MID_W'(m1_2_r);
    prod2     = P2_W'(z3_r) * P2_W'(mid3_r);
    case ({c4_r.low, c4_r.xneg})
      2'b10:   mag = MAG_W'(a4_r);
      2'b11:   mag = (MAG_W'(CDEG_HALF) << F) - MAG_W'(a4_r);
      2'b00:   mag = (MAG_W'(CDEG_QTR) << F) - MAG_W'(a4_r);
      default: mag = (MAG_W'(CDEG_QTR) << F) + MAG_W'(a4_r);
    endcase
    p_nxt = P3_W'(vd5_r) * P3_W'(RECIP100);
    rem   = vd7_r - prod7_r;
    qd    = (rem >= VDEG_W'(CENTI)) ? q0_7_r + 1'b1 : q0_7_r;
    qx    = {1'b0, qd};
    if (c7_r.spec) begin
      ang_nxt = c7_r.spec_deg;
    end else if (c7_r.yneg) begin
      ang_nxt = $signed(ANG_W'(~qx + 1'b1));
    end else begin
      ang_nxt = $signed(qx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      v_r       <= {v_r[6:1], q_pop};
      out_vld_r <= v_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r     <= q_z;
      inner1_r <= inner_nxt;
      c1_r     <= q_cls;

      z2_r     <= z1_r;
      m1_2_r   <= prod1[F +: INNER_W];
      c2_r     <= c1_r;

      z3_r     <= z2_r;
      mid3_r   <= mid_nxt;
      c3_r     <= c2_r;

      a4_r     <= prod2[F +: MID_W];
      c4_r     <= c3_r;

      vd5_r    <= mag[F +: VDEG_W];
      c5_r     <= c4_r;

      p6_r     <= p_nxt;
      vd6_r    <= vd5_r;
      c6_r     <= c5_r;

      q0_7_r   <= p6_r[RECIP_SHIFT +: QDEG_W];
      prod7_r  <= VDEG_W'(p6_r[RECIP_SHIFT +: QDEG_W]) * VDEG_W'(CENTI);
      vd7_r    <= vd6_r;
      c7_r     <= c6_r;

      ang_r    <= ang_nxt;
    end
  end

endmodule

FILE: sv/atan2_cubic_poly_degrees.sv
// Angle of a signed (x, y) pair in whole degrees, cubic octant approximation.
// One word per cycle sustained while out_stall is low.
// Front: fold plus a restoring divider, one quotient bit per stage (RATIO_FRAC_BITS + 1).
// Back: eight-stage cubic/unfold pipeline; a four-word queue parts the two.
// rst_n is synchronous active low; it empties both pipelines and the queue.
module atan2_cubic_poly_degrees
  import atcp_pkg::*;
#(
  parameter int COORD_WIDTH     = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ANG_W-1:0]       out_angle_deg
);

  localparam int Z_W = RATIO_FRAC_BITS + 1;
  localparam int QW  = Z_W + $bits(atcp_cls_t);

  logic            q_full, q_empty, q_push, q_pop;
  logic [Z_W-1:0]  f_z, b_z;
  atcp_cls_t       f_cls, b_cls;
  logic [QW-1:0]   q_wdata, q_rdata;

  assign q_wdata = {f_cls, f_z};
  assign b_z     = q_rdata[Z_W-1:0];
  assign b_cls   = atcp_cls_t'(q_rdata[QW-1:Z_W]);

  atcp_front #(
    .COORD_WIDTH    (COORD_WIDTH),
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_z       (f_z),
    .q_cls     (f_cls)
  );

  atcp_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  atcp_back #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_z          (b_z),
    .q_cls        (b_cls),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_angle_deg(out_angle_deg)
  );

endmodule

FILE: sv/atcp_chk.sv
// atcp_chk: port-level checks on the result channel, bound to the top level.
// No package dependencies.
module atcp_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic signed [8:0] out_angle_deg
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_angle_deg))
    else $error("stalled result word dropped or changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_deg > -9'sd180) && (out_angle_deg <= 9'sd180))
    else $error("angle outside -179..180");

endmodule

bind atan2_cubic_poly_degrees atcp_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_angle_deg(out_angle_deg)
);
